/* design/prime_set_store_core_defines.svh */
// Assertion macros shared by the prime set store design.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PRIME_SET_STORE_CORE_DEFINES_SVH
`define PRIME_SET_STORE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pss_pkg.sv */
package pss_pkg;

  // Store geometry.
  localparam int SET_DEPTH  = 16;
  localparam int VALUE_BITS = 16;

  // Port widths.
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Internal widths.
  localparam int CNT_BITS  = $clog2(SET_DEPTH + 1);
  localparam int IDX_BITS  = $clog2(SET_DEPTH);
  localparam int D_BITS    = VALUE_BITS / 2 + 2;
  localparam int SQ_BITS   = VALUE_BITS + 2;
  localparam int STEP_BITS = $clog2(VALUE_BITS);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_PRIME   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_read;
    logic scan_cmp;
    logic prime_step;
    logic div_start;
    logic mark_np;
    logic apply;
    logic shift_read;
    logic shift_write;
    logic shift_finish;
  } pss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_more;
    logic need_prime;
    logic small_value;
    logic sq_over;
    logic rem_done;
    logic rem_zero;
    logic need_shift;
    logic shift_more;
  } pss_stat_t;

endpackage

/* design/pss_rem.sv */
module pss_rem
  import pss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [D_BITS-1:0]     divisor,
  output logic                  done,
  output logic                  rem_zero
);

  logic [D_BITS-1:0]     rem;
  logic [VALUE_BITS-1:0] shreg;
  logic [STEP_BITS-1:0]  step;
  logic                  run;
  logic [D_BITS:0]       trial;
  logic [D_BITS:0]       diff;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign trial = {rem, shreg[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  // Control of the bit-serial remainder loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (step == '0);
      if (start) begin
        run <= 1'b1;
      end else if (run && (step == '0)) begin
        run <= 1'b0;
      end
    end
  end

  // Remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
      step  <= STEP_BITS'(VALUE_BITS - 1);
    end else if (run) begin
      rem   <= (trial >= {1'b0, divisor}) ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
      step  <= step - 1'b1;
    end
  end

  assign rem_zero = (rem == '0);

endmodule

/* design/pss_dp.sv */
module pss_dp
  import pss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  pss_cmd_t            cmd,
  input  logic [CMD_W-1:0]    command,
  input  logic [VALUE_W-1:0]  value,
  output pss_stat_t           stat,
  output logic [STATUS_W-1:0] status,
  output logic                found,
  output logic [COUNT_W-1:0]  count
);

  logic [VALUE_BITS-1:0] mem [SET_DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [IDX_BITS-1:0]   rd_addr;
  logic                  rd_en;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  wr_en;

  logic [CMD_W-1:0]      cmd_reg;
  logic [VALUE_BITS-1:0] val_reg;
  logic [CNT_BITS-1:0]   held_count;
  logic [CNT_BITS-1:0]   ptr;
  logic [CNT_BITS-1:0]   ptr_inc;
  logic [CNT_BITS-1:0]   pos;
  logic                  np;
  logic [D_BITS-1:0]     d;
  logic [SQ_BITS-1:0]    sq;
  logic                  is_insert;
  logic                  is_remove;
  logic                  full;
  logic                  ins_ok;
  logic                  rem_done;
  logic                  rem_zero;

  assign is_insert = (cmd_reg == CMD_INSERT);
  assign is_remove = (cmd_reg == CMD_REMOVE);
  assign full      = (held_count == CNT_BITS'(SET_DEPTH));
  assign ins_ok    = is_insert && !np && !found && !full;
  assign ptr_inc   = ptr + 1'b1;

  // Memory port selection: scan and shift reads, insert and shift writes.
  always_comb begin
    rd_en   = cmd.scan_read || cmd.shift_read;
    rd_addr = cmd.shift_read ? ptr_inc[IDX_BITS-1:0] : ptr[IDX_BITS-1:0];
    wr_en   = (cmd.apply && ins_ok) || cmd.shift_write;
    wr_addr = cmd.shift_write ? ptr[IDX_BITS-1:0] : held_count[IDX_BITS-1:0];
    wr_data = cmd.shift_write ? rd_data : val_reg;
  end

  // Entry store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Held count, the only register here that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.apply && ins_ok) begin
      held_count <= held_count + 1'b1;
    end else if (cmd.shift_finish) begin
      held_count <= held_count - 1'b1;
    end
  end

  // Command latch, scan pointer and lookup result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_reg <= command;
      val_reg <= value[VALUE_BITS-1:0];
      ptr     <= '0;
      found   <= 1'b0;
      pos     <= '0;
      np      <= 1'b0;
      d       <= D_BITS'(2);
      sq      <= SQ_BITS'(4);
    end else begin
      if (cmd.scan_cmp) begin
        if (rd_data == val_reg) begin
          found <= 1'b1;
          pos   <= ptr;
        end
        ptr <= ptr_inc;
      end
      if (cmd.apply) begin
        ptr <= pos;
      end
      if (cmd.shift_write) begin
        ptr <= ptr_inc;
      end
      if (cmd.mark_np) begin
        np <= 1'b1;
      end
      // After two only odd divisors are tried; (d+2)^2 = d^2 + 4d + 4.
      if (cmd.prime_step) begin
        if (d == D_BITS'(2)) begin
          d  <= D_BITS'(3);
          sq <= SQ_BITS'(9);
        end else begin
          d  <= d + D_BITS'(2);
          sq <= sq + SQ_BITS'({d, 2'b00}) + SQ_BITS'(4);
        end
      end
    end
  end

  // Status of the finished command.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      case (cmd_reg)
        CMD_INSERT: begin
          if (np) begin
            status <= ST_NOT_PRIME;
          end else if (found) begin
            status <= ST_PRESENT;
          end else if (full) begin
            status <= ST_FULL;
          end else begin
            status <= ST_DONE;
          end
        end
        CMD_REMOVE: begin
          if (np) begin
            status <= ST_NOT_PRIME;
          end else if (!found) begin
            status <= ST_NOT_PRESENT;
          end else begin
            status <= ST_DONE;
          end
        end
        default: begin
          status <= found ? ST_DONE : ST_NOT_PRESENT;
        end
      endcase
    end
  end

  // Remainder unit for trial division.
  pss_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (val_reg),
    .divisor  (d),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    stat.scan_more   = (ptr < held_count) && !found;
    stat.need_prime  = is_insert || is_remove;
    stat.small_value = (val_reg < VALUE_BITS'(2));
    stat.sq_over     = (sq > SQ_BITS'(val_reg));
    stat.rem_done    = rem_done;
    stat.rem_zero    = rem_zero;
    stat.need_shift  = is_remove && !np && found;
    stat.shift_more  = (ptr_inc < held_count);
  end

  assign count = COUNT_W'(held_count);

endmodule

/* design/pss_ctrl.sv */
module pss_ctrl
  import pss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pss_stat_t stat,
  output pss_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN_CHK  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP  = 4'd2;
  localparam logic [3:0] S_PRIME_CHK = 4'd3;
  localparam logic [3:0] S_DIV       = 4'd4;
  localparam logic [3:0] S_APPLY     = 4'd5;
  localparam logic [3:0] S_SHIFT_CHK = 4'd6;
  localparam logic [3:0] S_SHIFT_WR  = 4'd7;
  localparam logic [3:0] S_RESP      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.scan_more) begin
          cmd.scan_read = 1'b1;
          state_next    = S_SCAN_CMP;
        end else if (stat.need_prime) begin
          state_next = S_PRIME_CHK;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        state_next   = S_SCAN_CHK;
      end
      S_PRIME_CHK: begin
        if (stat.small_value) begin
          cmd.mark_np = 1'b1;
          state_next  = S_APPLY;
        end else if (stat.sq_over) begin
          state_next = S_APPLY;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.rem_done) begin
          if (stat.rem_zero) begin
            cmd.mark_np = 1'b1;
            state_next  = S_APPLY;
          end else begin
            cmd.prime_step = 1'b1;
            state_next     = S_PRIME_CHK;
          end
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = stat.need_shift ? S_SHIFT_CHK : S_RESP;
      end
      S_SHIFT_CHK: begin
        if (stat.shift_more) begin
          cmd.shift_read = 1'b1;
          state_next     = S_SHIFT_WR;
        end else begin
          cmd.shift_finish = 1'b1;
          state_next       = S_RESP;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        state_next      = S_SHIFT_CHK;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

endmodule

/* design/prime_set_store_core.sv */
// Prime set store: an ordered set of up to SET_DEPTH distinct prime values.
// Command channel: a beat (command, value) is taken at a clock edge where
// start is high and busy is low. Commands are insert, remove and find; an
// unused code behaves as find.
// Result channel: done is high for exactly one cycle with status, found and
// count. The receiver cannot hold a result off; it must take it then.
// busy stays high from the accepted beat through the done cycle, so one
// command is worked on at a time and the next can be given the cycle after.
// A command scans the held entries until a match or the end. Insert and
// remove then add a primality test by trial division over up to 128
// divisors (two, then odd ones), each run through the bit-serial
// remainder unit. A remove that finds its value then moves each later
// entry down one place to close the gap.
// Reset clears the held count and the controller; entry contents are not
// cleared, as only entries below the count are ever read.
module prime_set_store_core
  import pss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_W-1:0]    command,
  input  logic [VALUE_W-1:0]  value,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                found,
  output logic [COUNT_W-1:0]  count
);

`include "prime_set_store_core_defines.svh"

  pss_cmd_t  cmd;
  pss_stat_t stat;

  // Sequencing of scan, primality test, update and response.
  pss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Entry store, lookup, trial division and result registers.
  pss_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .command (command),
    .value   (value),
    .stat    (stat),
    .status  (status),
    .found   (found),
    .count   (count)
  );

  `PSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `PSS_ASSERT_NEXT(a_done_free, done, !busy, "block not ready after a result")
  `PSS_ASSERT_NOW(a_count_max, 1'b1, count <= COUNT_W'(SET_DEPTH), "held count above depth")
  `PSS_ASSERT_NOW(a_full_count, done && (status == ST_FULL), count == COUNT_W'(SET_DEPTH), "full status with room left")
  `PSS_ASSERT_NOW(a_found_status, done && found, status != ST_NOT_PRESENT, "held value reported as not present")

endmodule

/* test/prime_set_store_core_test.sv */
`timescale 1ns / 1ps

module prime_set_store_core_test;
  import pss_pkg::*;

  // The fourth command code has no name in the package; the block treats it as a find.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((1 << VALUE_BITS) - 1);
  localparam int RANDOM_ITEMS = 258;
  localparam int DRAIN_CYCLES = 40;
  // About 290 beats of the slowest insert or remove, with full sender gaps,
  // fit more than four times in this limit.
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] val;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [CMD_W-1:0]    command = CMD_INSERT;
  logic [VALUE_W-1:0]  value = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  count;

  command_t           command_queue[$];
  reply_t             expected_replies[$];
  logic [VALUE_W-1:0] shadow_primes[$];
  int                 prime_pool[$];

  int n_errors = 0;
  int n_total = 0;
  int n_sent = 0;
  int gap_left = 0;
  int cycle_count = 0;
  int op_tally[4] = '{0, 0, 0, 0};
  int status_tally[5] = '{0, 0, 0, 0, 0};
  logic taken;

  prime_set_store_core dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .value  (value),
    .busy   (busy),
    .done   (done),
    .status (status),
    .found  (found),
    .count  (count)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Trial division by every d with d*d <= v; values below 2 are not prime.
  function automatic bit prime_check(logic [VALUE_W-1:0] v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one command to the shadow store and returns the reply it should give.
  function automatic reply_t predict_reply(command_t c);
    reply_t r;
    logic [VALUE_W-1:0] v;
    int pos;
    v = c.val & VALUE_MASK;
    pos = -1;
    foreach (shadow_primes[i]) begin
      if (pos < 0 && shadow_primes[i] == v) pos = i;
    end
    r.found = (pos >= 0);
    if (c.op == CMD_INSERT) begin
      if (!prime_check(v)) r.status = ST_NOT_PRIME;
      else if (pos >= 0) r.status = ST_PRESENT;
      else if (shadow_primes.size() >= SET_DEPTH) r.status = ST_FULL;
      else begin
        shadow_primes.push_back(v);
        r.status = ST_DONE;
      end
    end else if (c.op == CMD_REMOVE) begin
      if (!prime_check(v)) r.status = ST_NOT_PRIME;
      else if (pos < 0) r.status = ST_NOT_PRESENT;
      else begin
        // Deleting from the queue closes the gap and keeps the order.
        shadow_primes.delete(pos);
        r.status = ST_DONE;
      end
    end else begin
      r.status = (pos >= 0) ? ST_DONE : ST_NOT_PRESENT;
    end
    r.count = COUNT_W'(shadow_primes.size());
    return r;
  endfunction

  task automatic queue_command(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] val);
    command_t c;
    c.op = op;
    c.val = val;
    command_queue.push_back(c);
  endtask

  // Sender idles in bursts, except in a quiet stretch of each 64 beats and near the end.
  function automatic bit bursts_on();
    return (n_sent % 64) < 44 && n_sent + 40 < n_total;
  endfunction

  // Driver: detect the accepted beat, predict its reply, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_replies.push_back(predict_reply(command_queue[0]));
        op_tally[command_queue[0].op]++;
        void'(command_queue.pop_front());
        n_sent++;
      end
      if (start && !taken) begin
        // The offered beat is still waiting for the block; hold it as is.
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (command_queue.size() == 0) begin
        start <= 1'b0;
      end else if (bursts_on() && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(0, 16);
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        command <= command_queue[0].op;
        value <= command_queue[0].val;
      end
    end
  end

  // Monitor: every done cycle carries one reply, checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (status < 5) status_tally[status]++;
      if (expected_replies.size() == 0) begin
        $error("reply with no command outstanding: status %0d found %0d count %0d",
               status, found, count);
        n_errors++;
      end else begin
        if (status !== expected_replies[0].status) begin
          $error("status: expected %0d, got %0d", expected_replies[0].status, status);
          n_errors++;
        end
        if (found !== expected_replies[0].found) begin
          $error("found: expected %0d, got %0d", expected_replies[0].found, found);
          n_errors++;
        end
        if (count !== expected_replies[0].count) begin
          $error("count: expected %0d, got %0d", expected_replies[0].count, count);
          n_errors++;
        end
        void'(expected_replies.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("prime_set_store_core: mismatch");
      $finish;
    end
  end

  // Stimulus, reset, and the final verdict.
  initial begin
    int r;
    int a;
    int b;
    logic [CMD_W-1:0] op;
    logic [VALUE_W-1:0] val;

    // Pool of primes: all small ones below 80, plus a few large ones that are slow to test.
    for (int v = 2; v < 80; v++) begin
      if (prime_check(VALUE_W'(v))) prime_pool.push_back(v);
    end
    prime_pool.push_back(257);
    prime_pool.push_back(32749);
    prime_pool.push_back(65519);
    prime_pool.push_back(65521);

    // Empty store, values below 2, squares and the all-ones value.
    queue_command(CMD_FIND, 16'd0);
    queue_command(CMD_REMOVE, 16'd2);
    queue_command(CMD_INSERT, 16'd0);
    queue_command(CMD_INSERT, 16'd1);
    queue_command(CMD_INSERT, 16'd63001);
    queue_command(CMD_INSERT, 16'hFFFF);
    queue_command(CMD_INSERT, 16'd65521);
    queue_command(CMD_INSERT, 16'd65521);
    queue_command(CMD_SPARE, 16'd65521);
    // Find skips the primality test; remove does not.
    queue_command(CMD_FIND, 16'd9);
    queue_command(CMD_REMOVE, 16'd9);
    // Fill the store, then try each insert outcome while it is full.
    for (int i = 0; i < SET_DEPTH - 1; i++) begin
      queue_command(CMD_INSERT, VALUE_W'(prime_pool[i]));
    end
    queue_command(CMD_INSERT, 16'd4);
    queue_command(CMD_INSERT, 16'd65521);
    queue_command(CMD_INSERT, VALUE_W'(prime_pool[SET_DEPTH - 1]));
    // Remove the first and the last entry, then append again.
    queue_command(CMD_REMOVE, 16'd65521);
    queue_command(CMD_REMOVE, VALUE_W'(prime_pool[SET_DEPTH - 2]));
    queue_command(CMD_INSERT, VALUE_W'(prime_pool[SET_DEPTH - 1]));

    // Random part: mostly pool primes so the store fills and empties, some noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = CMD_INSERT;
      else if (r < 70) op = CMD_REMOVE;
      else if (r < 95) op = CMD_FIND;
      else op = CMD_SPARE;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        val = VALUE_W'(prime_pool[$urandom_range(0, prime_pool.size() - 1)]);
      end else if (r < 85) begin
        a = prime_pool[$urandom_range(0, 21)];
        b = prime_pool[$urandom_range(0, 21)];
        val = VALUE_W'(a * b);
      end else begin
        val = VALUE_W'($urandom_range(0, 65535));
      end
      queue_command(op, val);
    end
    n_total = command_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (command_queue.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d insert, %0d remove, %0d find, %0d spare code.",
             n_sent, op_tally[CMD_INSERT], op_tally[CMD_REMOVE], op_tally[CMD_FIND],
             op_tally[CMD_SPARE]);
    $display("Replies: %0d done, %0d present, %0d absent, %0d not prime, %0d full.",
             status_tally[ST_DONE], status_tally[ST_PRESENT], status_tally[ST_NOT_PRESENT],
             status_tally[ST_NOT_PRIME], status_tally[ST_FULL]);
    if (n_errors == 0) begin
      $display("prime_set_store_core: match");
    end else begin
      $display("prime_set_store_core: mismatch");
    end
    $finish;
  end

endmodule
